/* rtl/segment_intersection_test_top_macros.svh */
// Assertion macros for the segment intersection test block.
// Used by the checker module; no other dependencies.
`ifndef SEGMENT_INTERSECTION_TEST_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_TOP_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define SIT_CHECK_NOW(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define SIT_CHECK_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sit_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the segment intersection test.
// No dependencies; sit_in_if, the stage modules, the top level and the testbench import this package.
package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  // Endpoints a, b of the first segment and c, d of the second.
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    coord_t dx;
    coord_t dy;
  } seg_pair_t;

  typedef struct packed {
    diff_t  rx;
    diff_t  ry;
    diff_t  sx;
    diff_t  sy;
    diff_t  qx;
    diff_t  qy;
    coord_t x_plo;
    coord_t x_phi;
    coord_t x_qlo;
    coord_t x_qhi;
    coord_t y_plo;
    coord_t y_phi;
    coord_t y_qlo;
    coord_t y_qhi;
  } delta_t;

  typedef struct packed {
    prod_t rx_sy;
    prod_t ry_sx;
    prod_t qx_sy;
    prod_t qy_sx;
    prod_t qx_ry;
    prod_t qy_rx;
    logic  ov_x;
    logic  ov_y;
  } prod_set_t;

  typedef struct packed {
    cross_t den;
    cross_t tn;
    cross_t un;
    logic   overlap;
  } cross_set_t;

  typedef struct packed {
    logic segments_meet;
    logic lines_parallel;
  } result_t;

  function automatic diff_t coord_sub(coord_t hi, coord_t lo);
    return diff_t'(hi) - diff_t'(lo);
  endfunction

  // num/den within [0,1] for a nonzero den, without dividing.
  function automatic logic ratio_in_unit(cross_t num, cross_t den);
    logic den_neg;
    logic num_neg;
    logic num_zero;
    den_neg  = den[CROSS_BITS-1];
    num_neg  = num[CROSS_BITS-1];
    num_zero = (num == '0);
    if (den_neg) begin
      return (num_neg || num_zero) && (num >= den);
    end else begin
      return !num_neg && (num <= den);
    end
  endfunction

endpackage

/* rtl/sit_in_if.sv */
`timescale 1ns / 1ps
// Input channel interface: valid/ready handshake with two segments as payload.
// Depends on sit_pkg.
interface sit_in_if import sit_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_end_x;
  coord_t second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

// Result channel interface: valid/ready handshake with the two flag bits.
interface sit_out_if ();
  logic valid;
  logic ready;
  logic segments_meet;
  logic lines_parallel;

  modport source (output valid, segments_meet, lines_parallel, input ready);
  modport sink (input valid, segments_meet, lines_parallel, output ready);
endinterface

/* rtl/sit_delta.sv */
`timescale 1ns / 1ps
// Stage 1: edge vectors r, s, q and ordered x/y interval ends.
// Depends on sit_pkg.
module sit_delta import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  seg_pair_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output delta_t    dn_data
);

  logic   valid_r;
  delta_t data_r;
  delta_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.rx    = coord_sub(up_data.bx, up_data.ax);
    data_nxt.ry    = coord_sub(up_data.by, up_data.ay);
    data_nxt.sx    = coord_sub(up_data.dx, up_data.cx);
    data_nxt.sy    = coord_sub(up_data.dy, up_data.cy);
    data_nxt.qx    = coord_sub(up_data.cx, up_data.ax);
    data_nxt.qy    = coord_sub(up_data.cy, up_data.ay);
    data_nxt.x_plo = (up_data.ax < up_data.bx) ? up_data.ax : up_data.bx;
    data_nxt.x_phi = (up_data.ax < up_data.bx) ? up_data.bx : up_data.ax;
    data_nxt.x_qlo = (up_data.cx < up_data.dx) ? up_data.cx : up_data.dx;
    data_nxt.x_qhi = (up_data.cx < up_data.dx) ? up_data.dx : up_data.cx;
    data_nxt.y_plo = (up_data.ay < up_data.by) ? up_data.ay : up_data.by;
    data_nxt.y_phi = (up_data.ay < up_data.by) ? up_data.by : up_data.ay;
    data_nxt.y_qlo = (up_data.cy < up_data.dy) ? up_data.cy : up_data.dy;
    data_nxt.y_qhi = (up_data.cy < up_data.dy) ? up_data.dy : up_data.cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/sit_product.sv */
`timescale 1ns / 1ps
// Stage 2: the six cross-product terms and the interval overlap flags.
// Depends on sit_pkg.
module sit_product import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  delta_t    up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output prod_set_t dn_data
);

  logic      valid_r;
  prod_set_t data_r;
  prod_set_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.rx_sy = prod_t'(up_data.rx) * prod_t'(up_data.sy);
    data_nxt.ry_sx = prod_t'(up_data.ry) * prod_t'(up_data.sx);
    data_nxt.qx_sy = prod_t'(up_data.qx) * prod_t'(up_data.sy);
    data_nxt.qy_sx = prod_t'(up_data.qy) * prod_t'(up_data.sx);
    data_nxt.qx_ry = prod_t'(up_data.qx) * prod_t'(up_data.ry);
    data_nxt.qy_rx = prod_t'(up_data.qy) * prod_t'(up_data.rx);
    // intervals overlap when each low end is at most the other's high end
    data_nxt.ov_x  = (up_data.x_plo <= up_data.x_qhi) && (up_data.x_qlo <= up_data.x_phi);
    data_nxt.ov_y  = (up_data.y_plo <= up_data.y_qhi) && (up_data.y_qlo <= up_data.y_phi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/sit_cross.sv */
`timescale 1ns / 1ps
// Stage 3: determinant and the two numerators from the registered products.
// Depends on sit_pkg.
module sit_cross import sit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  prod_set_t  up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cross_set_t dn_data
);

  logic       valid_r;
  cross_set_t data_r;
  cross_set_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.den     = cross_t'(up_data.rx_sy) - cross_t'(up_data.ry_sx);
    data_nxt.tn      = cross_t'(up_data.qx_sy) - cross_t'(up_data.qy_sx);
    data_nxt.un      = cross_t'(up_data.qx_ry) - cross_t'(up_data.qy_rx);
    data_nxt.overlap = up_data.ov_x && up_data.ov_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/sit_judge.sv */
`timescale 1ns / 1ps
// Stage 4: decide meet/parallel and hold the result in the output register.
// Depends on sit_pkg.
module sit_judge import sit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  cross_set_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output result_t    dn_data
);

  logic    valid_r;
  result_t data_r;
  result_t data_nxt;
  logic    par;
  logic    collinear;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // r x q and s x q are the negated numerators, so zero numerators mean collinear
  assign par       = (up_data.den == '0);
  assign collinear = (up_data.tn == '0) && (up_data.un == '0);

  always_comb begin
    data_nxt.lines_parallel = par;
    if (par) begin
      data_nxt.segments_meet = collinear && up_data.overlap;
    end else begin
      data_nxt.segments_meet = ratio_in_unit(up_data.tn, up_data.den) &&
                               ratio_in_unit(up_data.un, up_data.den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/segment_intersection_test_top.sv */
`timescale 1ns / 1ps
// Top level of the 2D segment intersection test: four-stage pipeline.
// Depends on sit_pkg, sit_in_if/sit_out_if, sit_delta, sit_product, sit_cross, sit_judge.
//
//   channel   | dir | payload
//   ----------+-----+------------------------------------------------------
//   in_chan   | in  | first/second start/end x,y (signed COORD_BITS each)
//   out_chan  | out | segments_meet, lines_parallel (1 bit each)
//
// Takes one transaction per cycle while the output is not stalled; each result passes
// through four registers (differences, multipliers, cross sums, then compare into the output register).
// Each stage holds its own valid bit; a stalled output backs up stage by stage
// and empty stages keep taking data, so nothing is lost or repeated.
// Synchronous active-low reset clears only the valid bits.
module segment_intersection_test_top import sit_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_chan,
  sit_out_if.source out_chan
);

  seg_pair_t  in_data;
  logic       d_valid;
  logic       d_ready;
  delta_t     d_data;
  logic       p_valid;
  logic       p_ready;
  prod_set_t  p_data;
  logic       c_valid;
  logic       c_ready;
  cross_set_t c_data;
  result_t    res_data;

  assign in_data.ax = in_chan.first_start_x;
  assign in_data.ay = in_chan.first_start_y;
  assign in_data.bx = in_chan.first_end_x;
  assign in_data.by = in_chan.first_end_y;
  assign in_data.cx = in_chan.second_start_x;
  assign in_data.cy = in_chan.second_start_y;
  assign in_data.dx = in_chan.second_end_x;
  assign in_data.dy = in_chan.second_end_y;

  sit_delta u_delta (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_data  (in_data),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_data  (d_data)
  );

  sit_product u_product (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d_valid),
    .up_ready (d_ready),
    .up_data  (d_data),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_data  (p_data)
  );

  sit_cross u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_data  (p_data),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  sit_judge u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid),
    .up_ready (c_ready),
    .up_data  (c_data),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_data  (res_data)
  );

  assign out_chan.segments_meet  = res_data.segments_meet;
  assign out_chan.lines_parallel = res_data.lines_parallel;

endmodule

/* rtl/sit_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for segment_intersection_test_top, attached by bind.
// Depends on segment_intersection_test_top_macros.svh.
`include "segment_intersection_test_top_macros.svh"

module sit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_meet,
  input logic out_par
);

  logic       stall;
  logic [1:0] flags;

  assign stall = out_valid && !out_ready;
  assign flags = {out_meet, out_par};

  // a held result keeps its flags while the sink stalls
  `SIT_CHECK_NEXT(a_out_hold, clk, !rst_n, stall, out_valid && $stable(flags), "held result changed")

  // reset empties every stage
  `SIT_CHECK_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid, "output valid right after reset")

  // an empty output register or a ready sink lets the whole pipe advance
  `SIT_CHECK_NOW(a_no_false_stall, clk, !rst_n, !stall, in_ready, "input stalled without cause")

endmodule

bind segment_intersection_test_top sit_checker u_sit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_meet  (out_chan.segments_meet),
  .out_par   (out_chan.lines_parallel)
);

/* test/segment_intersection_test_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for segment_intersection_test_top: directed and random segment pairs
// against an integer cross-product predictor. Depends on sit_pkg and sit_in_if/sit_out_if.
module segment_intersection_test_top_tb;
  import sit_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_PAIRS = 1425;
  localparam int SETTLE       = 8;

  class meet_scoreboard;
    result_t expected_flags[$];
    int      mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function longint cross_of(longint ux, longint uy, longint vx, longint vy);
      return ux * vy - uy * vx;
    endfunction

    function bit ratio_within(longint num, longint den);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      return num >= 0 && num <= den;
    endfunction

    function bit spans_touch(longint p0, longint p1, longint q0, longint q1);
      longint plo, phi, qlo, qhi;
      plo = (p0 < p1) ? p0 : p1;
      phi = (p0 < p1) ? p1 : p0;
      qlo = (q0 < q1) ? q0 : q1;
      qhi = (q0 < q1) ? q1 : q0;
      return ((plo > qlo) ? plo : qlo) <= ((phi < qhi) ? phi : qhi);
    endfunction

    function result_t predict_flags(seg_pair_t p);
      result_t res;
      longint ax, ay, bx, by, cx, cy, dx, dy;
      longint rx, ry, sx, sy, qx, qy, det;
      ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
      cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
      rx = bx - ax; ry = by - ay;
      sx = dx - cx; sy = dy - cy;
      qx = cx - ax; qy = cy - ay;
      det = cross_of(rx, ry, sx, sy);
      res.lines_parallel = (det == 0);
      if (det != 0) begin
        res.segments_meet = ratio_within(cross_of(qx, qy, sx, sy), det)
                         && ratio_within(cross_of(qx, qy, rx, ry), det);
      end else begin
        // parallel: must be on one line and overlap on both axes
        res.segments_meet = cross_of(rx, ry, qx, qy) == 0
                         && cross_of(sx, sy, qx, qy) == 0
                         && spans_touch(ax, bx, cx, dx)
                         && spans_touch(ay, by, cy, dy);
      end
      return res;
    endfunction

    function void note_pair(seg_pair_t p);
      expected_flags.push_back(predict_flags(p));
    endfunction

    function void check_flags(result_t got);
      result_t want;
      if (expected_flags.size() == 0) begin
        $display("%0t: unexpected result meet=%0b parallel=%0b", $time,
                 got.segments_meet, got.lines_parallel);
        mismatch_count++;
        return;
      end
      want = expected_flags.pop_front();
      if (got.segments_meet !== want.segments_meet) begin
        $display("%0t: segments_meet expected %0b actual %0b", $time,
                 want.segments_meet, got.segments_meet);
        mismatch_count++;
      end
      if (got.lines_parallel !== want.lines_parallel) begin
        $display("%0t: lines_parallel expected %0b actual %0b", $time,
                 want.lines_parallel, got.lines_parallel);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sit_in_if  in_if ();
  sit_out_if out_if ();

  segment_intersection_test_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  meet_scoreboard sb = new();
  int stall_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int signed_pick(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic coord_t rim_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(-32768);
      1: return coord_t'(-32767);
      2: return coord_t'(-1);
      3: return coord_t'(0);
      4: return coord_t'(1);
      5: return coord_t'(32766);
      6: return coord_t'(32767);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic seg_pair_t mk(int ax, int ay, int bx, int by,
                                   int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p.ax = coord_t'(ax); p.ay = coord_t'(ay);
    p.bx = coord_t'(bx); p.by = coord_t'(by);
    p.cx = coord_t'(cx); p.cy = coord_t'(cy);
    p.dx = coord_t'(dx); p.dy = coord_t'(dy);
    return p;
  endfunction

  // Mix of fully random, clustered, collinear, point, endpoint-on-line and extreme-coordinate pairs.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    seg_pair_t t;
    int kind, px, py, ux, uy, k0, k1, k2, k3;
    kind = $urandom_range(0, 99);
    px = signed_pick(30000);
    py = signed_pick(30000);
    ux = signed_pick(8);
    uy = signed_pick(8);
    k0 = signed_pick(8);
    k1 = signed_pick(8);
    k2 = signed_pick(8);
    k3 = signed_pick(8);
    p = {$urandom, $urandom, $urandom, $urandom};
    if (kind < 25) begin
      return p;
    end else if (kind < 55) begin
      p = mk(px + signed_pick(6), py + signed_pick(6), px + signed_pick(6),
             py + signed_pick(6), px + signed_pick(6), py + signed_pick(6),
             px + signed_pick(6), py + signed_pick(6));
    end else if (kind < 70) begin
      p = mk(px + k0 * ux, py + k0 * uy, px + k1 * ux, py + k1 * uy,
             px + k2 * ux, py + k2 * uy, px + k3 * ux, py + k3 * uy);
    end else if (kind < 80) begin
      p = mk(px + k0 * ux, py + k0 * uy, px + k0 * ux, py + k0 * uy,
             px + k2 * ux, py + k2 * uy, px + k3 * ux, py + k3 * uy);
      if ($urandom_range(0, 2) == 0) begin
        p.dx = coord_t'(px + signed_pick(6));
        p.dy = coord_t'(py + signed_pick(6));
      end
      if ($urandom_range(0, 1) == 1) begin
        t = p;
        p = mk(t.cx, t.cy, t.dx, t.dy, t.ax, t.ay, t.bx, t.by);
      end
    end else if (kind < 90) begin
      p = mk(px + k0 * ux, py + k0 * uy, px + k1 * ux, py + k1 * uy,
             px + k2 * ux, py + k2 * uy, px + k2 * ux + signed_pick(8),
             py + k2 * uy + signed_pick(8));
    end else begin
      p.ax = rim_coord(); p.ay = rim_coord(); p.bx = rim_coord(); p.by = rim_coord();
      p.cx = rim_coord(); p.cy = rim_coord(); p.dx = rim_coord(); p.dy = rim_coord();
    end
    return p;
  endfunction

  task automatic send_pair(seg_pair_t p);
    in_if.valid          <= 1'b1;
    in_if.first_start_x  <= p.ax;
    in_if.first_start_y  <= p.ay;
    in_if.first_end_x    <= p.bx;
    in_if.first_end_y    <= p.by;
    in_if.second_start_x <= p.cx;
    in_if.second_start_y <= p.cy;
    in_if.second_end_x   <= p.dx;
    in_if.second_end_y   <= p.dy;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off new transactions until every expected result is back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: ready bursts with random stalls.
  initial begin : sink_side
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : monitor
    seg_pair_t seen;
    result_t   got;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        seen = mk(in_if.first_start_x, in_if.first_start_y, in_if.first_end_x,
                  in_if.first_end_y, in_if.second_start_x, in_if.second_start_y,
                  in_if.second_end_x, in_if.second_end_y);
        sb.note_pair(seen);
      end
      if (out_if.valid && out_if.ready) begin
        got.segments_meet  = out_if.segments_meet;
        got.lines_parallel = out_if.lines_parallel;
        sb.check_flags(got);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : source_side
    bit quiet;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.first_start_x  <= '0;
    in_if.first_start_y  <= '0;
    in_if.first_end_x    <= '0;
    in_if.first_end_y    <= '0;
    in_if.second_start_x <= '0;
    in_if.second_start_y <= '0;
    in_if.second_end_x   <= '0;
    in_if.second_end_y   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // crossing and near-miss lines
    send_pair(mk(-10, -10, 10, 10, -10, 10, 10, -10));
    send_pair(mk(0, 0, 1, 1, 5, 0, 6, -1));
    send_pair(mk(0, 0, 10, 0, 5, 0, 5, 7));
    pause_sender(idle_gap());
    send_pair(mk(0, 0, 4, 4, 4, 4, 8, 0));
    send_pair(mk(0, 0, 10, 0, 5, 1, 5, 7));
    send_pair(mk(10, 0, 0, 10, 0, 0, 10, 10));
    send_pair(mk(0, 0, 2, 2, 3, 3, 5, 1));
    // parallel and collinear
    send_pair(mk(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(mk(0, 0, 10, 0, 5, 0, 15, 0));
    pause_sender(idle_gap());
    send_pair(mk(0, 0, 4, 4, 5, 5, 9, 9));
    send_pair(mk(4, 4, 0, 0, 8, 8, 4, 4));
    send_pair(mk(3, 9, 3, 1, 3, 5, 3, 20));
    send_pair(mk(0, 0, 3, 0, 4, 0, 8, 0));
    // single-point segments
    send_pair(mk(2, 2, 2, 2, 0, 0, 4, 4));
    send_pair(mk(2, 3, 2, 3, 0, 0, 4, 4));
    send_pair(mk(0, 0, 4, 4, 4, 4, 4, 4));
    send_pair(mk(7, -7, 7, -7, 7, -7, 7, -7));
    send_pair(mk(7, -7, 7, -7, 7, -6, 7, -6));
    // full-range coordinates
    send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(mk(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
    send_pair(mk(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    drain_results();

    quiet = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_pair(random_pair());
      if (i % 400 == 399) begin
        drain_results();
      end else if (!quiet) begin
        pause_sender(idle_gap());
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
